// ----- rtl/rlrm_pkg.sv -----
// Package for the run-length range mapper: word types, status codes, defaults.
`default_nettype none

package rlrm_pkg;

  // Default capacity of the run table
  localparam int unsigned MAX_RUNS_DEFAULT = 1024;

  // Fixed result field widths
  localparam int unsigned IDX_W = 11;
  localparam int unsigned LEN_W = 31;
  localparam int unsigned POS_W = 32;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_MAP    = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    STATUS_OK            = 3'd0,
    STATUS_TOO_LONG      = 3'd1,
    STATUS_TABLE_FULL    = 3'd2,
    STATUS_INVALID_RANGE = 3'd3,
    STATUS_OUT_OF_BOUNDS = 3'd4
  } status_t;

  // Input word
  typedef struct packed {
    cmd_t                    cmd;
    logic                    new_table;
    logic [LEN_W-1:0]        run_length;
    logic                    range_missing;
    logic signed [POS_W-1:0] pos_first;
    logic signed [POS_W-1:0] pos_last;
  } item_t;

  // Result word
  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] first_run;
    logic [IDX_W-1:0] span;
    logic [LEN_W-1:0] left_trim;
    logic [LEN_W-1:0] right_trim;
  } result_t;

  // Map job handed from the front to the back (run count travels beside it)
  typedef struct packed {
    status_t                 status;
    logic signed [POS_W-1:0] pos_first;
    logic signed [POS_W-1:0] pos_last;
  } map_job_t;

endpackage

`default_nettype wire

// ----- rtl/run_length_range_mapper_core.sv -----
// Top level of the run-length range mapper: front, job queue, back, run table.
//
//   channel  | handshake                  | word
//   ---------+----------------------------+-----------------
//   item     | item_valid / item_stall    | item   (item_t)
//   result   | result_valid / result_stall| result (result_t)
//
// A map word runs two binary searches in the back over the N stored runs,
// each step an address state then a compare state on the table's single
// read port, then two reads for trims. Errored maps skip the searches and
// zero-width maps run only the first. Synchronous reset clears counts,
// flags, queue and sequencer; the table needs no clearing. Two map words
// queue up; an append that starts a new table stalls while any map word is
// pending.
`default_nettype none

module run_length_range_mapper_core
  import rlrm_pkg::*;
#(
  parameter int unsigned MAX_RUNS = MAX_RUNS_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output      logic    item_stall,
  input  wire item_t   item,
  output      logic    result_valid,
  input  wire logic    result_stall,
  output      result_t result
);

  localparam int unsigned CW = $clog2(MAX_RUNS + 1);
  localparam int unsigned AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int unsigned JB = $bits(map_job_t);
  localparam int unsigned QW = JB + CW;

  logic             job_push;
  map_job_t         job_in;
  logic [CW-1:0]    count_in;
  logic             q_full;
  logic             q_empty;
  logic             job_pop;
  logic [QW-1:0]    q_rdata;
  map_job_t         job_out;
  logic [CW-1:0]    count_out;
  logic             back_busy;
  logic             table_busy;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [LEN_W-1:0] wr_data;
  logic [AW-1:0]    rd_addr;
  logic [LEN_W-1:0] rd_data;

  assign table_busy = !q_empty || back_busy;
  assign job_out    = map_job_t'(q_rdata[JB-1:0]);
  assign count_out  = q_rdata[QW-1 -: CW];

  rlrm_front #(.MAX_RUNS(MAX_RUNS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .table_busy (table_busy),
    .job_push   (job_push),
    .job        (job_in),
    .job_count  (count_in),
    .queue_full (q_full),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  rlrm_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data ({count_in, job_in}),
    .full      (q_full),
    .pop       (job_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  rlrm_ram #(.WIDTH(LEN_W), .DEPTH(MAX_RUNS)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rlrm_back #(.MAX_RUNS(MAX_RUNS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (!q_empty),
    .job          (job_out),
    .job_count    (count_out),
    .job_pop      (job_pop),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .busy         (back_busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// ----- rtl/rlrm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rlrm_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [AW-1:0]          wr_addr,
  input  wire logic [WIDTH-1:0]       wr_data,
  input  wire logic [AW-1:0]          rd_addr,
  output      logic [WIDTH-1:0]       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/rlrm_front.sv -----
// Front end: takes input words, applies appends to the table, classifies map words.
`default_nettype none

module rlrm_front
  import rlrm_pkg::*;
#(
  parameter int unsigned MAX_RUNS = MAX_RUNS_DEFAULT,
  localparam int unsigned CW = $clog2(MAX_RUNS + 1),
  localparam int unsigned AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output      logic            item_stall,
  input  wire item_t           item,
  input  wire logic            table_busy,
  output      logic            job_push,
  output      map_job_t        job,
  output      logic [CW-1:0]   job_count,
  input  wire logic            queue_full,
  output      logic            wr_en,
  output      logic [AW-1:0]   wr_addr,
  output      logic [LEN_W-1:0] wr_data
);

  logic [CW-1:0]    run_count;
  logic [LEN_W-1:0] total_length;
  logic             too_long;
  logic             table_full;

  logic             accept;
  logic [CW-1:0]    cnt_c;
  logic [LEN_W-1:0] tot_c;
  logic             flags_c;
  logic [LEN_W:0]   sum;
  logic             len_zero;
  logic             cnt_max;
  logic signed [POS_W:0] start_m1;
  logic signed [POS_W:0] end_x;
  logic             bad_range;
  logic             oob;

  // Maps wait for queue room; a table restart waits until no map reads the table
  always_comb begin
    if (item.cmd == CMD_MAP) begin
      item_stall = queue_full;
    end else begin
      item_stall = item.new_table && table_busy;
    end
  end

  assign accept = item_valid && !item_stall;

  // Append path
  always_comb begin
    cnt_c    = item.new_table ? '0 : run_count;
    tot_c    = item.new_table ? '0 : total_length;
    flags_c  = item.new_table ? 1'b0 : (too_long || table_full);
    sum      = {1'b0, tot_c} + {1'b0, item.run_length};
    len_zero = (item.run_length == '0);
    cnt_max  = (cnt_c == CW'(MAX_RUNS));
  end

  assign wr_en   = accept && (item.cmd == CMD_APPEND) && !len_zero && !flags_c &&
                   !cnt_max && !sum[LEN_W];
  assign wr_addr = cnt_c[AW-1:0];
  assign wr_data = sum[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count    <= '0;
      total_length <= '0;
      too_long     <= 1'b0;
      table_full   <= 1'b0;
    end else if (accept && item.cmd == CMD_APPEND) begin
      if (len_zero || flags_c) begin
        run_count    <= cnt_c;
        total_length <= tot_c;
        too_long     <= too_long && !item.new_table;
        table_full   <= table_full && !item.new_table;
      end else if (cnt_max) begin
        run_count    <= cnt_c;
        total_length <= tot_c;
        too_long     <= 1'b0;
        table_full   <= 1'b1;
      end else if (sum[LEN_W]) begin
        run_count    <= cnt_c;
        total_length <= tot_c;
        too_long     <= 1'b1;
        table_full   <= 1'b0;
      end else begin
        run_count    <= cnt_c + CW'(1);
        total_length <= sum[LEN_W-1:0];
        too_long     <= 1'b0;
        table_full   <= 1'b0;
      end
    end
  end

  // Map classification, in priority order
  always_comb begin
    start_m1  = $signed({item.pos_first[POS_W-1], item.pos_first}) - 33'sd1;
    end_x     = $signed({item.pos_last[POS_W-1], item.pos_last});
    bad_range = item.range_missing || (end_x < start_m1);
    oob       = (item.pos_first < 32'sd1) ||
                (item.pos_last > $signed({1'b0, total_length}));
    job.pos_first = item.pos_first;
    job.pos_last  = item.pos_last;
    if (too_long) begin
      job.status = STATUS_TOO_LONG;
    end else if (table_full) begin
      job.status = STATUS_TABLE_FULL;
    end else if (bad_range) begin
      job.status = STATUS_INVALID_RANGE;
    end else if (oob) begin
      job.status = STATUS_OUT_OF_BOUNDS;
    end else begin
      job.status = STATUS_OK;
    end
  end

  assign job_push  = accept && (item.cmd == CMD_MAP);
  assign job_count = run_count;

endmodule

`default_nettype wire

// ----- rtl/rlrm_queue.sv -----
// Two-entry queue of map jobs between front and back.
`default_nettype none

module rlrm_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output      logic             full,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] pop_data,
  output      logic             empty
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rlrm_back.sv -----
// Back end: binary searches the run table for each map job and drives results.
`default_nettype none

module rlrm_back
  import rlrm_pkg::*;
#(
  parameter int unsigned MAX_RUNS = MAX_RUNS_DEFAULT,
  localparam int unsigned CW = $clog2(MAX_RUNS + 1),
  localparam int unsigned AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             job_valid,
  input  wire map_job_t         job,
  input  wire logic [CW-1:0]    job_count,
  output      logic             job_pop,
  output      logic [AW-1:0]    rd_addr,
  input  wire logic [LEN_W-1:0] rd_data,
  output      logic             busy,
  output      logic             result_valid,
  input  wire logic             result_stall,
  output      result_t          result
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_ADDR      = 7'b0000010,
    S_CMP       = 7'b0000100,
    S_RD_BEFORE = 7'b0001000,
    S_RD_END    = 7'b0010000,
    S_RD_DONE   = 7'b0100000,
    S_RESULT    = 7'b1000000
  } state_t;

  state_t           state;
  logic             last_phase;
  logic [CW-1:0]    lo;
  logic [CW-1:0]    hi;
  logic [CW-1:0]    first;
  logic [CW-1:0]    count;
  logic [POS_W-1:0] target;
  logic [POS_W-1:0] start_pos;
  logic [POS_W-1:0] end_pos;
  logic             has_width;
  logic [LEN_W-1:0] prior_end;
  result_t          res;

  logic [CW:0]      mid_sum;
  logic [CW-1:0]    mid;
  logic [CW-1:0]    first_m1;
  logic             out_free;

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[CW:1];
  assign first_m1 = first - CW'(1);
  assign out_free = !result_valid || !result_stall;
  assign busy     = (state != S_IDLE);
  assign job_pop  = (state == S_IDLE) && job_valid;

  // Table read address
  always_comb begin
    case (state)
      S_RD_BEFORE: rd_addr = first_m1[AW-1:0];
      S_RD_END:    rd_addr = lo[AW-1:0];
      default:     rd_addr = mid[AW-1:0];
    endcase
  end

  // Search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      last_phase   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_RESULT) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            start_pos      <= job.pos_first;
            end_pos        <= job.pos_last;
            has_width      <= (job.pos_last >= job.pos_first);
            count          <= job_count;
            lo             <= '0;
            hi             <= job_count;
            target         <= job.pos_first;
            last_phase     <= 1'b0;
            res.status     <= job.status;
            res.first_run  <= '0;
            res.span       <= '0;
            res.left_trim  <= '0;
            res.right_trim <= '0;
            if (job.status == STATUS_OK) begin
              state <= S_ADDR;
            end else begin
              state <= S_RESULT;
            end
          end
        end
        S_ADDR: begin
          if (lo == hi) begin
            if (!last_phase) begin
              first <= lo;
              if (has_width) begin
                hi         <= count;
                target     <= end_pos;
                last_phase <= 1'b1;
              end else begin
                res.first_run <= IDX_W'(lo);
                state         <= S_RESULT;
              end
            end else begin
              state <= S_RD_BEFORE;
            end
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if ({1'b0, rd_data} < target) begin
            lo <= mid + CW'(1);
          end else begin
            hi <= mid;
          end
          state <= S_ADDR;
        end
        S_RD_BEFORE: begin
          state <= S_RD_END;
        end
        S_RD_END: begin
          prior_end <= (first == '0) ? '0 : rd_data;
          state     <= S_RD_DONE;
        end
        S_RD_DONE: begin
          res.first_run  <= IDX_W'(first);
          res.span       <= IDX_W'(lo - first + CW'(1));
          res.left_trim  <= start_pos[LEN_W-1:0] - LEN_W'(1) - prior_end;
          res.right_trim <= rd_data - end_pos[LEN_W-1:0];
          state          <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            result       <= res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rlrm_checker.sv -----
// Port-level checker for the run-length range mapper, bound to the top level.
`default_nettype none

module rlrm_checker
  import rlrm_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    item_valid,
  input wire logic    item_stall,
  input wire item_t   item,
  input wire logic    result_valid,
  input wire logic    result_stall,
  input wire result_t result
);

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // A stalled input word holds
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("stalled input word changed");

  // A stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("stalled result word changed");

  // Error results carry only the status
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != STATUS_OK |->
      result.first_run == '0 && result.span == '0 &&
      result.left_trim == '0 && result.right_trim == '0)
    else $error("error result with nonzero fields");

  // Zero-width ranges give no trims
  a_zero_width: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.span == '0 |->
      result.left_trim == '0 && result.right_trim == '0)
    else $error("zero span with nonzero trim");

endmodule

bind run_length_range_mapper_core rlrm_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

// ----- sim/map_result_checker.sv -----
// Checker for the run-length range mapper: mirrors the run table, predicts map results, compares.
`timescale 1ns / 1ps

module map_result_checker
  import rlrm_pkg::*;
#(
  parameter int unsigned MAX_RUNS = MAX_RUNS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  item_t       item,
  input  logic        result_valid,
  input  logic        result_stall,
  input  result_t     result,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  localparam longint LEN_MAX = 64'h7FFF_FFFF;

  // Mirror of the block's run table
  logic [LEN_W-1:0] run_ends [MAX_RUNS];
  int unsigned      stored_runs = 0;
  logic [LEN_W-1:0] total_len = '0;
  logic             too_long = 1'b0;
  logic             table_full = 1'b0;

  // Map results still owed by the block, oldest first
  result_t     owed_maps [$];
  int unsigned error_count = 0;

  assign mismatches  = error_count;
  assign outstanding = owed_maps.size();

  // First stored run whose end reaches pos, or the run count
  function automatic int unsigned locate_run(input longint pos);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = stored_runs;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (longint'(run_ends[mid]) < pos) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Append one run length, honoring the clear flag and the sticky errors
  function automatic void append_run(input logic clear, input logic [LEN_W-1:0] len);
    longint sum;
    if (clear) begin
      stored_runs = 0;
      total_len   = '0;
      too_long    = 1'b0;
      table_full  = 1'b0;
    end
    if (len == '0 || too_long || table_full) return;
    if (stored_runs >= MAX_RUNS) begin
      table_full = 1'b1;
      return;
    end
    sum = longint'(total_len) + longint'(len);
    if (sum > LEN_MAX) begin
      too_long = 1'b1;
      return;
    end
    total_len = LEN_W'(sum);
    run_ends[stored_runs] = total_len;
    stored_runs++;
  endfunction

  // Expected result of one map word against the current table
  function automatic result_t map_range(input item_t w);
    result_t     r;
    longint      first_pos, last_pos, prior_end;
    int unsigned f, e;
    r = '0;
    first_pos = longint'(w.pos_first);
    last_pos  = longint'(w.pos_last);
    if (too_long) r.status = STATUS_TOO_LONG;
    else if (table_full) r.status = STATUS_TABLE_FULL;
    else if (w.range_missing || last_pos < first_pos - 1) r.status = STATUS_INVALID_RANGE;
    else if (first_pos < 1 || last_pos > longint'(total_len)) r.status = STATUS_OUT_OF_BOUNDS;
    else begin
      r.status = STATUS_OK;
      f = locate_run(first_pos);
      r.first_run = IDX_W'(f);
      // zero width keeps span and trims at zero
      if (last_pos >= first_pos) begin
        e = locate_run(last_pos);
        prior_end = (f >= 1) ? longint'(run_ends[f-1]) : 64'sd0;
        r.span       = IDX_W'(e - f + 1);
        r.left_trim  = LEN_W'(first_pos - 1 - prior_end);
        r.right_trim = LEN_W'(longint'(run_ends[e]) - last_pos);
      end
    end
    return r;
  endfunction

  // Watch both channels at the rising edge
  always @(posedge clk) begin : watch
    result_t oldest;
    if (rst) begin
      stored_runs = 0;
      total_len   = '0;
      too_long    = 1'b0;
      table_full  = 1'b0;
      owed_maps.delete();
    end else begin
      // results first: a word accepted now cannot answer an item accepted now
      if (result_valid && !result_stall) begin
        if (owed_maps.size() == 0) begin
          error_count++;
          $display("%0t: result word with none expected: status %0d first %0d span %0d",
                   $time, result.status, result.first_run, result.span);
        end else begin
          oldest = owed_maps.pop_front();
          if (result.status !== oldest.status || result.first_run !== oldest.first_run ||
              result.span !== oldest.span || result.left_trim !== oldest.left_trim ||
              result.right_trim !== oldest.right_trim) begin
            error_count++;
            $display("%0t: map mismatch: expected status %0d first %0d span %0d ltrim %0d rtrim %0d",
                     $time, oldest.status, oldest.first_run, oldest.span,
                     oldest.left_trim, oldest.right_trim);
            $display("%0t:               actual status %0d first %0d span %0d ltrim %0d rtrim %0d",
                     $time, result.status, result.first_run, result.span,
                     result.left_trim, result.right_trim);
          end
        end
      end
      if (item_valid && !item_stall) begin
        if (item.cmd == CMD_MAP) owed_maps.push_back(map_range(item));
        else append_run(item.new_table, item.run_length);
      end
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Testbench top for the run-length range mapper: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import rlrm_pkg::*;

  localparam int unsigned MAX_RUNS     = MAX_RUNS_DEFAULT;
  localparam longint      LEN_MAX      = 64'h7FFF_FFFF;
  localparam int unsigned RANDOM_ITEMS = 250;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 100;

  logic        clk = 1'b0;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  item_t       item_word;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result_word;
  int unsigned mismatches;
  int unsigned outstanding;

  // Stimulus-side view of the table, used only to aim map ranges
  longint      aim_ends [$];
  longint      aim_total = 0;
  logic        aim_err = 1'b0;
  logic        quiet = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  always #6 clk = ~clk;

  run_length_range_mapper_core #(.MAX_RUNS(MAX_RUNS)) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_word)
  );

  map_result_checker #(.MAX_RUNS(MAX_RUNS)) result_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_word),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // Receiver backpressure, off during the quiet stretch
  always @(negedge clk) begin
    result_stall <= !quiet && ($urandom_range(99) < 26);
  end

  // Any 32-bit position except the most negative code
  function automatic logic signed [POS_W-1:0] any_pos();
    logic [POS_W-1:0] v;
    v = $urandom;
    if (v == 32'h8000_0000) v = 32'h8000_0001;
    return v;
  endfunction

  // Keep an aimed position inside the field's range
  function automatic logic signed [POS_W-1:0] clamp_pos(input longint p);
    if (p > LEN_MAX) return POS_W'(LEN_MAX);
    if (p < -LEN_MAX) return POS_W'(-LEN_MAX);
    return POS_W'(p);
  endfunction

  // Run length by style: small, medium, full width, or landing near the length limit
  function automatic logic [LEN_W-1:0] pick_len(input int unsigned style, input logic last);
    case (style)
      0: return LEN_W'($urandom_range(16, 1));
      1: return LEN_W'($urandom_range(100000, 1));
      2: return LEN_W'($urandom);
      default: begin
        if (!last) return LEN_W'($urandom_range(1 << 24, 1));
        return LEN_W'(LEN_MAX - aim_total + $urandom_range(2) - 1);
      end
    endcase
  endfunction

  // Offer one word, with random idle cycles ahead of it; called at a falling edge
  task automatic send_word(input item_t w);
    while (!quiet && $urandom_range(99) < 26) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item_word  <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Append word; range fields carry noise
  task automatic send_run(input logic clear, input logic [LEN_W-1:0] len);
    item_t w;
    w.cmd           = CMD_APPEND;
    w.new_table     = clear;
    w.run_length    = len;
    w.range_missing = 1'($urandom);
    w.pos_first     = any_pos();
    w.pos_last      = any_pos();
    send_word(w);
    if (clear) begin
      aim_ends.delete();
      aim_total = 0;
      aim_err   = 1'b0;
    end
    if (len != '0 && !aim_err) begin
      if (aim_ends.size() >= MAX_RUNS || aim_total + longint'(len) > LEN_MAX) aim_err = 1'b1;
      else begin
        aim_total += longint'(len);
        aim_ends.push_back(aim_total);
      end
    end
  endtask

  // Map word; append fields carry noise
  task automatic send_map(input logic missing, input longint s, input longint e);
    item_t w;
    w.cmd           = CMD_MAP;
    w.new_table     = 1'($urandom);
    w.run_length    = LEN_W'($urandom);
    w.range_missing = missing;
    w.pos_first     = clamp_pos(s);
    w.pos_last      = clamp_pos(e);
    send_word(w);
  endtask

  // Map with a range aimed at the current table, its edges, or anywhere
  task automatic send_random_map();
    longint      s, e, lo_i, lo_j;
    int unsigned roll, n, i, j;
    roll = $urandom_range(99);
    n = aim_ends.size();
    if (roll < 50) begin
      s = $urandom_range(32'(aim_total + 1), 1);
      e = s - 1 + $urandom_range(32'(aim_total - s + 1), 0);
      send_map(1'b0, s, e);
    end else if (roll < 72 && n > 0) begin
      // land on run boundaries
      i = $urandom_range(n - 1);
      j = $urandom_range(n - 1, i);
      lo_i = (i == 0) ? 1 : aim_ends[i-1] + 1;
      lo_j = (j == 0) ? 1 : aim_ends[j-1] + 1;
      s = $urandom_range(1) ? lo_i : aim_ends[i];
      case ($urandom_range(2))
        0: e = aim_ends[j];
        1: e = s - 1;
        default: e = (lo_j >= s) ? lo_j : aim_ends[j];
      endcase
      send_map(1'b0, s, e);
    end else if (roll < 85) begin
      // edges of the valid window
      case ($urandom_range(4))
        0: s = 0;
        1: s = 1;
        2: s = aim_total;
        3: s = aim_total + 1;
        default: s = -1;
      endcase
      case ($urandom_range(3))
        0: e = s - 2;
        1: e = s - 1;
        2: e = aim_total;
        default: e = aim_total + 1;
      endcase
      send_map(1'b0, s, e);
    end else if (roll < 92) begin
      send_map(1'b1, 1, aim_total);
    end else begin
      send_map(1'($urandom_range(3) == 0), longint'(any_pos()), longint'(any_pos()));
    end
  endtask

  // Run-length cap on the whole run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned random_base, phase_no, roll, style, n_runs, k;
    logic        clear;
    logic [LEN_W-1:0] len;

    rst        = 1'b1;
    item_valid = 1'b0;
    item_word  = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, limits, each status but table full, sticky errors, clearing
    send_map(1'b0, 1, 0);
    send_map(1'b0, 1, 1);
    send_run(1'b1, 5);
    send_run(1'b0, 0);
    send_run(1'b0, 3);
    send_run(1'b0, LEN_W'(LEN_MAX - 8));
    send_map(1'b1, 1, 5);
    send_map(1'b0, 5, 3);
    send_map(1'b0, 0, 4);
    send_map(1'b0, 1, LEN_MAX);
    send_map(1'b0, 6, 6);
    send_map(1'b0, 9, 8);
    send_map(1'b0, LEN_MAX, LEN_MAX);
    send_map(1'b0, -LEN_MAX, LEN_MAX);
    send_map(1'b0, LEN_MAX, -LEN_MAX);
    send_map(1'b0, 3, 7);
    send_run(1'b0, 1);
    send_run(1'b0, 4);
    send_map(1'b0, 1, 1);
    send_run(1'b1, 0);
    send_map(1'b0, 1, 0);
    send_run(1'b0, LEN_W'(LEN_MAX));
    send_map(1'b0, 2, LEN_MAX - 1);
    send_map(1'b1, -LEN_MAX, -LEN_MAX);

    // Fill the table to capacity, map it, then overflow it
    send_run(1'b1, LEN_W'($urandom_range(2000, 1)));
    for (k = 1; k < MAX_RUNS; k++) send_run(1'b0, LEN_W'($urandom_range(2000, 1)));
    send_map(1'b0, aim_total + 1, aim_total);
    send_map(1'b0, 1, aim_total);
    repeat (4) send_random_map();
    send_run(1'b0, 7);
    send_run(1'b0, 0);
    repeat (2) send_random_map();

    // Random phases: mostly a table built then mapped, some noise
    random_base = items_sent;
    phase_no = 0;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      quiet = (phase_no >= 8 && phase_no < 15);
      roll = $urandom_range(99);
      if (roll < 8) begin
        repeat ($urandom_range(12, 4)) begin
          if ($urandom_range(1)) send_run(1'($urandom_range(4) == 0), LEN_W'($urandom));
          else send_map(1'($urandom), longint'(any_pos()), longint'(any_pos()));
        end
      end else begin
        roll = $urandom_range(99);
        style = (roll < 40) ? 0 : (roll < 70) ? 1 : (roll < 80) ? 2 : 3;
        n_runs = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
        for (k = 0; k < n_runs; k++) begin
          clear = (k == 0) && ($urandom_range(4) != 0);
          len = ($urandom_range(15) == 0) ? '0 : pick_len(style, k == n_runs - 1);
          send_run(clear, len);
          // a stray map in the middle of a build
          if ($urandom_range(19) == 0) send_random_map();
        end
        repeat ($urandom_range(10, 1)) send_random_map();
      end
      phase_no++;
    end
    quiet = 1'b0;
    item_valid <= 1'b0;

    // Drain every owed result, then let the block settle
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
